>>> rtl/core/pma_pkg.sv
// pma_pkg: sizes, codes and shared types of the polynomial multiply/add block.
// No dependencies; every other file refers to it by scoped names.
package pma_pkg;

	localparam int MaxTerms  = 16;
	localparam int ProdDepth = 2 * MaxTerms - 1;
	localparam int IdxW      = $clog2(MaxTerms);
	localparam int ProdW     = $clog2(ProdDepth);

	localparam int OpW      = 2;
	localparam int InCoefW  = 11;
	localparam int InExpW   = 4;
	localparam int CoefW    = 32;
	localparam int ExpW     = 5;

	typedef enum logic [OpW-1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_RUN    = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		KIND_PRODUCT = 1'b0,
		KIND_SUM     = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_WALK_P,
		ST_ZERO_P,
		ST_WALK_S,
		ST_ZERO_S,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic             kind;
		logic [CoefW-1:0] coef;
		logic [ExpW-1:0]  expo;
	} term_t;

	typedef struct packed {
		logic             load_a;
		logic             load_b;
		logic             mac;
		logic [IdxW-1:0]  i;
		logic [IdxW-1:0]  j;
		logic             step_p;
		logic [ProdW-1:0] pidx;
		logic             step_s;
		logic [IdxW-1:0]  sidx;
		logic             zero;
		logic             zero_kind;
		logic             flush;
	} cmd_t;

	typedef struct packed {
		logic cand_nz;
		logic push_ok;
	} stat_t;

endpackage

>>> rtl/core/pma_ifs.sv
// Handshake channels of the polynomial multiply/add block: term input and result output.
// Depends on pma_pkg for field widths.
interface pma_in_if;
	logic                                valid;
	logic                                ready;
	logic [pma_pkg::OpW-1:0]             op;
	logic signed [pma_pkg::InCoefW-1:0]  coefficient;
	logic [pma_pkg::InExpW-1:0]          exponent;

	modport source (output valid, op, coefficient, exponent, input ready);
	modport sink   (input valid, op, coefficient, exponent, output ready);
endinterface

interface pma_out_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic signed [pma_pkg::CoefW-1:0]  coefficient_out;
	logic [pma_pkg::ExpW-1:0]          exponent_out;
	logic                              last;

	modport source (output valid, kind, coefficient_out, exponent_out, last, input ready);
	modport sink   (input valid, kind, coefficient_out, exponent_out, last, output ready);
endinterface

>>> rtl/core/pma_datapath.sv
// pma_datapath: coefficient stores, multiply-accumulate pipe, term walk and output register.
// Depends on pma_pkg; driven by pma_ctrl through cmd_t, reports through stat_t.
module pma_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pma_pkg::cmd_t                       cmd,
	output pma_pkg::stat_t                      stat,
	input  logic signed [pma_pkg::InCoefW-1:0]  coefficient,
	input  logic [pma_pkg::InExpW-1:0]          exponent,
	input  logic                                out_ready,
	output logic                                out_valid,
	output pma_pkg::term_t                      out_term,
	output logic                                out_last
);

	logic [pma_pkg::CoefW-1:0] a_q    [pma_pkg::MaxTerms];
	logic [pma_pkg::CoefW-1:0] b_q    [pma_pkg::MaxTerms];
	logic [pma_pkg::CoefW-1:0] prod_q [pma_pkg::ProdDepth];

	logic [pma_pkg::CoefW-1:0] mul_s1;
	logic [pma_pkg::ProdW-1:0] k_s1;
	logic                      acc_s1;

	pma_pkg::term_t pend_q;
	logic           pend_valid_q;
	pma_pkg::term_t out_q;
	logic           out_last_q;
	logic           out_valid_q;

	logic [pma_pkg::CoefW-1:0] coef_ext;
	logic                      exp_ok;
	logic [pma_pkg::IdxW-1:0]  ld_idx;
	logic [pma_pkg::CoefW-1:0] sum_val;
	pma_pkg::term_t            cand;
	pma_pkg::term_t            new_term;
	logic                      take;

	assign coef_ext = {{(pma_pkg::CoefW - pma_pkg::InCoefW){coefficient[pma_pkg::InCoefW-1]}},
		coefficient};
	assign exp_ok = (pma_pkg::InExpW+1)'(exponent) < (pma_pkg::InExpW+1)'(pma_pkg::MaxTerms);
	assign ld_idx = exponent[pma_pkg::IdxW-1:0];
	assign sum_val = a_q[cmd.sidx] + b_q[cmd.sidx];

	always_comb begin
		if (cmd.step_s) begin
			cand.kind = pma_pkg::KIND_SUM;
			cand.coef = sum_val;
			cand.expo = pma_pkg::ExpW'(cmd.sidx);
		end else begin
			cand.kind = pma_pkg::KIND_PRODUCT;
			cand.coef = prod_q[cmd.pidx];
			cand.expo = pma_pkg::ExpW'(cmd.pidx);
		end
		if (cmd.zero) begin
			new_term.kind = cmd.zero_kind;
			new_term.coef = '0;
			new_term.expo = '0;
		end else begin
			new_term = cand;
		end
	end

	assign take = cmd.zero || ((cmd.step_p || cmd.step_s) && (cand.coef != '0));

	assign stat.cand_nz = cand.coef != '0;
	assign stat.push_ok = !out_valid_q || out_ready;

	// stores: loads, accumulate, clear at end of run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '{default: '0};
			b_q    <= '{default: '0};
			prod_q <= '{default: '0};
		end else if (cmd.flush) begin
			a_q    <= '{default: '0};
			b_q    <= '{default: '0};
			prod_q <= '{default: '0};
		end else begin
			if (cmd.load_a && exp_ok)
				a_q[ld_idx] <= a_q[ld_idx] + coef_ext;
			if (cmd.load_b && exp_ok)
				b_q[ld_idx] <= b_q[ld_idx] + coef_ext;
			if (acc_s1)
				prod_q[k_s1] <= prod_q[k_s1] + mul_s1;
		end
	end

	// multiply stage; accumulate happens the cycle after
	always_ff @(posedge clk) begin
		mul_s1 <= a_q[cmd.i] * b_q[cmd.j];
		k_s1   <= pma_pkg::ProdW'(cmd.i) + pma_pkg::ProdW'(cmd.j);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_s1 <= 1'b0;
		else
			acc_s1 <= cmd.mac;
	end

	// one term held back so the final transfer can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
			if ((take && pend_valid_q) || cmd.flush)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			pend_q <= new_term;
		if ((take && pend_valid_q) || cmd.flush) begin
			out_q      <= pend_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign out_term  = out_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/core/pma_ctrl.sv
// pma_ctrl: run sequencer of the polynomial multiply/add block (loads, MAC sweep, walks).
// Depends on pma_pkg; commands pma_datapath through cmd_t.
module pma_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pma_pkg::OpW-1:0]       op,
	input  pma_pkg::stat_t                stat,
	output pma_pkg::cmd_t                 cmd
);

	localparam logic [pma_pkg::IdxW-1:0]  IdxLast  = pma_pkg::IdxW'(pma_pkg::MaxTerms - 1);
	localparam logic [pma_pkg::ProdW-1:0] ProdLast = pma_pkg::ProdW'(pma_pkg::ProdDepth - 1);

	pma_pkg::state_t state_q, state_d;
	logic [pma_pkg::IdxW-1:0]  i_q, i_d, j_q, j_d, sidx_q, sidx_d;
	logic [pma_pkg::ProdW-1:0] pidx_q, pidx_d;
	logic                      found_q, found_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pma_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			pidx_q  <= '0;
			sidx_q  <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			pidx_q  <= pidx_d;
			sidx_q  <= sidx_d;
			found_q <= found_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		pidx_d   = pidx_q;
		sidx_d   = sidx_q;
		found_d  = found_q;
		in_ready = 1'b0;
		cmd           = '0;
		cmd.i         = i_q;
		cmd.j         = j_q;
		cmd.pidx      = pidx_q;
		cmd.sidx      = sidx_q;

		case (state_q)
			pma_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op)
						pma_pkg::OP_LOAD_A: cmd.load_a = 1'b1;
						pma_pkg::OP_LOAD_B: cmd.load_b = 1'b1;
						pma_pkg::OP_RUN: begin
							i_d     = '0;
							j_d     = '0;
							state_d = pma_pkg::ST_MAC;
						end
						default: ;
					endcase
				end
			end
			pma_pkg::ST_MAC: begin
				cmd.mac = 1'b1;
				j_d = j_q + 1'b1;
				if (j_q == IdxLast) begin
					j_d = '0;
					i_d = i_q + 1'b1;
					if (i_q == IdxLast)
						state_d = pma_pkg::ST_DRAIN;
				end
			end
			pma_pkg::ST_DRAIN: begin
				// last accumulate lands this cycle
				pidx_d  = ProdLast;
				found_d = 1'b0;
				state_d = pma_pkg::ST_WALK_P;
			end
			pma_pkg::ST_WALK_P: begin
				if (stat.push_ok) begin
					cmd.step_p = 1'b1;
					found_d = found_q || stat.cand_nz;
					pidx_d  = pidx_q - 1'b1;
					if (pidx_q == '0) begin
						sidx_d  = IdxLast;
						found_d = 1'b0;
						state_d = (found_q || stat.cand_nz) ? pma_pkg::ST_WALK_S
							: pma_pkg::ST_ZERO_P;
					end
				end
			end
			pma_pkg::ST_ZERO_P: begin
				if (stat.push_ok) begin
					cmd.zero      = 1'b1;
					cmd.zero_kind = pma_pkg::KIND_PRODUCT;
					state_d       = pma_pkg::ST_WALK_S;
				end
			end
			pma_pkg::ST_WALK_S: begin
				if (stat.push_ok) begin
					cmd.step_s = 1'b1;
					found_d = found_q || stat.cand_nz;
					sidx_d  = sidx_q - 1'b1;
					if (sidx_q == '0)
						state_d = (found_q || stat.cand_nz) ? pma_pkg::ST_FLUSH
							: pma_pkg::ST_ZERO_S;
				end
			end
			pma_pkg::ST_ZERO_S: begin
				if (stat.push_ok) begin
					cmd.zero      = 1'b1;
					cmd.zero_kind = pma_pkg::KIND_SUM;
					state_d       = pma_pkg::ST_FLUSH;
				end
			end
			pma_pkg::ST_FLUSH: begin
				// final term goes out with last; stores clear
				if (stat.push_ok) begin
					cmd.flush = 1'b1;
					state_d   = pma_pkg::ST_IDLE;
				end
			end
			default: state_d = pma_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/polynomial_multiply_add.sv
// polynomial_multiply_add: top level, joins sequencer and datapath to the two channels.
// Depends on pma_pkg, pma_ifs, pma_ctrl and pma_datapath.
//
//  channel  dir  carries                                          transfer when
//  items    in   op, coefficient, exponent                        valid && ready
//  results  out  kind, coefficient_out, exponent_out, last        valid && ready
//
// Loads are taken back to back while idle.
// A run sweeps every pair of A and B terms through one 32x32 multiplier with
// multiply-accumulate, drains, walks each product and sum store entry
// (2*MaxTerms-1 plus MaxTerms), emits any zero term and flushes.
// Result back-pressure stalls the walk; no item is taken during a run.
// Reset clears all stores; the stores clear again after each run.
module polynomial_multiply_add (
	input logic        clk,
	input logic        arst_n,
	pma_in_if.sink     items,
	pma_out_if.source  results
);

	pma_pkg::cmd_t  cmd;
	pma_pkg::stat_t stat;
	pma_pkg::term_t out_term;

	pma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.op       (items.op),
		.stat     (stat),
		.cmd      (cmd)
	);

	pma_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.coefficient (items.coefficient),
		.exponent    (items.exponent),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.out_term    (out_term),
		.out_last    (results.last)
	);

	assign results.kind            = out_term.kind;
	assign results.coefficient_out = out_term.coef;
	assign results.exponent_out    = out_term.expo;

endmodule
